FILE: rtl/core/glrd_pkg.sv
// ----------------------------------------------------------------------------
// glrd_pkg
// Shared types and constants of the GIF LZW raster decoder: item commands,
// status codes, register indexes, interlace tables and the control structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package glrd_pkg;

  // Size of the LZW string table and the widths that follow from it.
  localparam int unsigned CODE_BITS = 12;
  localparam int unsigned CNT_BITS  = 13;
  localparam logic [CNT_BITS-1:0] TABLE_CODES = 13'd4096;
  localparam logic [CNT_BITS-1:0] USED_LIMIT  = 13'd4095;
  localparam logic [3:0] MAX_CODE_WIDTH = 4'd12;

  // Command carried by each input item.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_PULL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Status codes reported with every result item.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEED = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_MIN_CODE  = 3'd0;
  localparam logic [2:0] REG_WIDTH     = 3'd1;
  localparam logic [2:0] REG_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_INTERLACE = 3'd3;
  localparam logic [2:0] REG_COLORS    = 3'd4;
  localparam logic [2:0] REG_TRANS_EN  = 3'd5;
  localparam logic [2:0] REG_TRANS_IDX = 3'd6;

  // First row of each interlace pass.
  function automatic logic [16:0] pass_start(input logic [1:0] pass);
    logic [16:0] v;
    case (pass)
      2'd0:    v = 17'd0;
      2'd1:    v = 17'd4;
      2'd2:    v = 17'd2;
      default: v = 17'd1;
    endcase
    return v;
  endfunction

  // Row step of each interlace pass.
  function automatic logic [16:0] pass_step(input logic [1:0] pass);
    logic [16:0] v;
    case (pass)
      2'd0:    v = 17'd8;
      2'd1:    v = 17'd8;
      2'd2:    v = 17'd4;
      default: v = 17'd2;
    endcase
    return v;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic extract;
    logic decode;
    logic walk;
    logic pull;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t op;
    logic drain_ok;
    logic dec_walk;
    logic walk_cont;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/core/gif_lzw_raster_decoder_top.sv
// ----------------------------------------------------------------------------
// gif_lzw_raster_decoder_top
// GIF LZW raster decoder: decodes the image-data bytes of one frame into
// palette indices with frame coordinates, one result item per input item.
// ----------------------------------------------------------------------------
// Usage: each input item carries a command in in_tuser (start frame, offer
// the byte in in_tdata, pull a pixel) and returns exactly one result item
// with status, byte_taken and, for pulls, the pixel fields; out_tlast marks
// the final pixel of the frame. Configuration registers are to be written by
// the user through the cfg channel, which is always ready, only while no item
// is in flight; the block itself does not enforce this. An accepted item runs
// EXEC, then CHK, which extracts each whole code in the bit buffer, then DONE,
// which loads the output register; a pull runs PRD and PULL before CHK.
// Each code is decoded in DEC and its prefix chain walked in WALK, one table
// read a cycle through one registered read port per table. Items are handled
// one at a time; in_tready is high only while idle. The result waits in an
// output register; a stalled receiver holds the block before it loads the
// next result, but a finished result never blocks input. Reset clears the
// control state and loads the register defaults; the code tables and string
// stack need no clearing, since the decoder reads only entries it has written.
module gif_lzw_raster_decoder_top
  import glrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [2] byte_taken, [3] pixel_valid, [11:4] pixel_index,
  // [27:12] pixel_x, [43:28] pixel_y, [44] is_transparent, [47:45] zero
  output logic [47:0] out_tdata,
  output logic        out_tlast,  // last_pixel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  glrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  glrd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/core/glrd_ctrl.sv
// ----------------------------------------------------------------------------
// glrd_ctrl
// Controller state machine: sequences command execution, code extraction,
// prefix chain walks, pixel pulls and the hand-off of each result item.
// ----------------------------------------------------------------------------
module glrd_ctrl
  import glrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EXEC = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_DEC  = 8'b0000_1000,
    S_WALK = 8'b0001_0000,
    S_PRD  = 8'b0010_0000,
    S_PULL = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (stat.op == CMD_PULL) ? S_PRD : S_CHK;
      end
      S_CHK: begin
        if (stat.drain_ok) begin
          cmd.extract = 1'b1;
          state_nxt   = S_DEC;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        state_nxt  = stat.dec_walk ? S_WALK : S_CHK;
      end
      S_WALK: begin
        cmd.walk  = 1'b1;
        state_nxt = stat.walk_cont ? S_WALK : S_CHK;
      end
      S_PRD: begin
        state_nxt = S_PULL;
      end
      S_PULL: begin
        cmd.pull  = 1'b1;
        state_nxt = S_CHK;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/glrd_datapath.sv
// ----------------------------------------------------------------------------
// glrd_datapath
// Decoder datapath: configuration registers, bit buffer, LZW code tables,
// string stack, raster position counters and the result register.
// ----------------------------------------------------------------------------
module glrd_datapath
  import glrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tlast
);

  // Configuration registers.
  logic [3:0]  min_r;
  logic [15:0] width_r, height_r;
  logic        inter_r, ten_r;
  logic [8:0]  ccount_r;
  logic [7:0]  tidx_r;
  logic [31:0] total_r;

  // Decoder state.
  logic [CNT_BITS-1:0] depth_r, depth_nxt, next_r, next_nxt, prev_r, prev_nxt;
  logic [CNT_BITS-1:0] cur_r, cur_nxt, used_r, used_nxt;
  logic [19:0] bbuf_r, bbuf_nxt;
  logic [4:0]  bcnt_r, bcnt_nxt;
  logic [7:0]  brem_r, brem_nxt, first_r, first_nxt;
  logic [3:0]  cw_r, cw_nxt;
  logic        prev_v_r, prev_v_nxt;
  logic [15:0] col_r, col_nxt, row_r, row_nxt;
  logic [1:0]  pass_r, pass_nxt, doe_r, doe_nxt;
  logic [31:0] pix_r, pix_nxt;
  logic [CODE_BITS-1:0] code_r, code_nxt;
  cmd_t        op_r, op_nxt;
  logic [7:0]  byte_r, byte_nxt;

  // Pending result fields.
  logic        taken_r, taken_nxt, pv_r, pv_nxt, trans_r, trans_nxt, last_r, last_nxt;
  logic [7:0]  pidx_r, pidx_nxt;
  logic [15:0] px_r, px_nxt, py_r, py_nxt;

  // Output register.
  logic        ovalid_r;
  logic [47:0] odata_r;
  logic        olast_r;

  // Memories.
  logic [CODE_BITS-1:0] prefix_mem [TABLE_CODES];
  logic [7:0]           suffix_mem [TABLE_CODES];
  logic [7:0]           stack_mem  [TABLE_CODES];
  logic [CODE_BITS-1:0] pre_rd_r;
  logic [7:0]           suf_rd_r, stk_rd_r;
  logic                 tab_we, st_we;
  logic [CODE_BITS-1:0] st_waddr, stk_raddr;
  logic [7:0]           st_wdata;

  // Derived values.
  logic [3:0]  m_eff;
  logic [CNT_BITS-1:0] clear_c, endc_c, code13, cnt, pre13;
  logic [19:0] byte_sh;
  logic [CODE_BITS-1:0] code_ext;
  logic        is_clear, is_end, is_kwk, dec_bad, walk_bad, fit_bad;
  logic [1:0]  status_c;
  logic [15:0] col_inc;
  logic        row_end;
  logic [1:0]  adv_p;
  logic [16:0] adv_y;

  // Code size and the special codes that follow from it.
  always_comb begin
    if (min_r < 4'd2) begin
      m_eff = 4'd2;
    end else if (min_r > 4'd8) begin
      m_eff = 4'd8;
    end else begin
      m_eff = min_r;
    end
  end
  assign clear_c = 13'd1 << m_eff;
  assign endc_c  = clear_c + 13'd1;
  assign code13  = {1'b0, code_r};
  assign pre13   = {1'b0, pre_rd_r};
  assign cnt     = used_r + 13'd1;
  assign byte_sh = {12'b0, byte_r} << bcnt_r;
  assign code_ext = bbuf_r[11:0] & ((12'd1 << cw_r) - 12'd1);

  // Classification of an extracted code.
  assign is_clear = (code13 == clear_c);
  assign is_end   = (code13 == endc_c);
  assign is_kwk   = prev_v_r && (code13 == next_r) && (next_r < TABLE_CODES);
  assign dec_bad  = prev_v_r ? ((code13 >= next_r) && !is_kwk) : (code13 >= clear_c);

  // Checks during a prefix chain step and at the end of the string.
  assign walk_bad = (cur_r <= endc_c) || (cur_r >= next_r) || (used_r >= USED_LIMIT) ||
                    cur_r[CNT_BITS-1];
  assign fit_bad  = (pix_r > total_r) ||
                    (({1'b0, pix_r} + {20'b0, cnt}) > {1'b0, total_r});

  // Raster position after one pixel, interlace passes included.
  assign col_inc = col_r + 16'd1;
  assign row_end = (col_inc >= width_r);
  always_comb begin
    adv_p = pass_r;
    adv_y = {1'b0, row_r} + pass_step(pass_r);
    for (int i = 0; i < 3; i++) begin
      if ((adv_y >= {1'b0, height_r}) && (adv_p != 2'd3)) begin
        adv_p = adv_p + 2'd1;
        adv_y = pass_start(adv_p);
      end
    end
  end

  // Status of the block after the current item.
  assign status_c = (doe_r != 2'd0) ? doe_r : ((depth_r != '0) ? ST_OK : ST_NEED);

  // Status toward the controller.
  assign stat.op        = op_r;
  assign stat.drain_ok  = (doe_r == 2'd0) && (depth_r == '0) && (bcnt_r >= {1'b0, cw_r});
  assign stat.dec_walk  = !is_clear && !is_end && !dec_bad;
  assign stat.walk_cont = (cur_r >= clear_c) && !walk_bad && (pre13 < cur_r);
  assign stat.out_busy  = ovalid_r && !out_tready;

  assign stk_raddr = depth_r[CODE_BITS-1:0] - 12'd1;

  // Next-state logic of the decoder.
  always_comb begin
    depth_nxt = depth_r;  next_nxt = next_r;   prev_nxt = prev_r;
    cur_nxt   = cur_r;    used_nxt = used_r;   bbuf_nxt = bbuf_r;
    bcnt_nxt  = bcnt_r;   brem_nxt = brem_r;   first_nxt = first_r;
    cw_nxt    = cw_r;     prev_v_nxt = prev_v_r;
    col_nxt   = col_r;    row_nxt  = row_r;    pass_nxt = pass_r;
    doe_nxt   = doe_r;    pix_nxt  = pix_r;    code_nxt = code_r;
    op_nxt    = op_r;     byte_nxt = byte_r;
    taken_nxt = taken_r;  pv_nxt   = pv_r;     trans_nxt = trans_r;
    last_nxt  = last_r;   pidx_nxt = pidx_r;   px_nxt = px_r;   py_nxt = py_r;
    tab_we    = 1'b0;     st_we    = 1'b0;
    st_waddr  = used_r[CODE_BITS-1:0];
    st_wdata  = first_r;

    // Take in a new item and clear the result fields.
    if (cmd.capture) begin
      op_nxt    = cmd_t'(in_tuser);
      byte_nxt  = in_tdata;
      taken_nxt = 1'b0;  pv_nxt = 1'b0;  trans_nxt = 1'b0;  last_nxt = 1'b0;
      pidx_nxt  = '0;    px_nxt = '0;    py_nxt = '0;
    end

    // Frame start or a data byte.
    if (cmd.exec) begin
      case (op_r)
        CMD_START: begin
          depth_nxt = '0;  bbuf_nxt = '0;  bcnt_nxt = '0;  brem_nxt = '0;
          next_nxt  = clear_c + 13'd2;  cw_nxt = m_eff + 4'd1;
          prev_nxt  = '0;  prev_v_nxt = 1'b0;  first_nxt = '0;
          col_nxt   = '0;  row_nxt = '0;  pass_nxt = '0;  pix_nxt = '0;
          doe_nxt   = 2'd0;
        end
        CMD_BYTE: begin
          if ((doe_r == 2'd0) && (depth_r == '0)) begin
            taken_nxt = 1'b1;
            if (brem_r == 8'd0) begin
              if (byte_r == 8'd0) begin
                doe_nxt = ST_ERR;
              end else begin
                brem_nxt = byte_r;
              end
            end else begin
              brem_nxt = brem_r - 8'd1;
              bbuf_nxt = bbuf_r | byte_sh;
              bcnt_nxt = bcnt_r + 5'd8;
            end
          end
        end
        default: ;
      endcase
    end

    // Pull one code off the bit buffer.
    if (cmd.extract) begin
      code_nxt = code_ext;
      bbuf_nxt = bbuf_r >> cw_r;
      bcnt_nxt = bcnt_r - {1'b0, cw_r};
    end

    // Act on the code or set up the chain walk.
    if (cmd.decode) begin
      if (is_clear) begin
        next_nxt   = endc_c + 13'd1;
        cw_nxt     = m_eff + 4'd1;
        prev_v_nxt = 1'b0;
      end else if (is_end) begin
        doe_nxt = (pix_r == total_r) ? ST_DONE : ST_ERR;
      end else if (dec_bad) begin
        doe_nxt = ST_ERR;
      end else if (is_kwk) begin
        st_we    = 1'b1;
        st_waddr = '0;
        st_wdata = first_r;
        used_nxt = 13'd1;
        cur_nxt  = prev_r;
      end else begin
        used_nxt = '0;
        cur_nxt  = code13;
      end
    end

    // One step of the prefix chain, or the end of the string.
    if (cmd.walk) begin
      if (cur_r >= clear_c) begin
        if (walk_bad) begin
          doe_nxt = ST_ERR;
        end else begin
          st_we    = 1'b1;
          st_wdata = suf_rd_r;
          used_nxt = cnt;
          if (pre13 >= cur_r) begin
            doe_nxt = ST_ERR;
          end else begin
            cur_nxt = pre13;
          end
        end
      end else begin
        first_nxt = cur_r[7:0];
        st_we     = 1'b1;
        st_wdata  = cur_r[7:0];
        if (fit_bad) begin
          doe_nxt = ST_ERR;
        end else begin
          depth_nxt = cnt;
          if (prev_v_r && (next_r < TABLE_CODES)) begin
            tab_we   = 1'b1;
            next_nxt = next_r + 13'd1;
            if (((next_r + 13'd1) == (13'd1 << cw_r)) && (cw_r < MAX_CODE_WIDTH)) begin
              cw_nxt = cw_r + 4'd1;
            end
          end
          prev_nxt   = code13;
          prev_v_nxt = 1'b1;
        end
      end
    end

    // Hand out the top pixel of the string.
    if (cmd.pull) begin
      if ((doe_r == 2'd0) && (depth_r != '0)) begin
        depth_nxt = depth_r - 13'd1;
        if ({1'b0, stk_rd_r} >= ccount_r) begin
          doe_nxt = ST_ERR;
        end else begin
          pv_nxt    = 1'b1;
          pidx_nxt  = stk_rd_r;
          px_nxt    = col_r;
          py_nxt    = row_r;
          trans_nxt = ten_r && (stk_rd_r == tidx_r);
          last_nxt  = (({1'b0, pix_r} + 33'd1) == {1'b0, total_r});
          pix_nxt   = pix_r + 32'd1;
          col_nxt   = col_inc;
          if (row_end) begin
            col_nxt = '0;
            if (!inter_r) begin
              row_nxt = row_r + 16'd1;
            end else begin
              pass_nxt = adv_p;
              row_nxt  = adv_y[15:0];
            end
          end
        end
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;  bbuf_r <= '0;  bcnt_r <= '0;  brem_r <= '0;
      next_r  <= 13'd258;  cw_r <= 4'd9;  prev_r <= '0;  prev_v_r <= 1'b0;
      first_r <= '0;  col_r <= '0;  row_r <= '0;  pass_r <= '0;
      pix_r   <= '0;  doe_r <= 2'd0;  op_r <= CMD_NONE;
      ovalid_r <= 1'b0;
    end else begin
      depth_r <= depth_nxt;  bbuf_r <= bbuf_nxt;  bcnt_r <= bcnt_nxt;
      brem_r  <= brem_nxt;   next_r <= next_nxt;  cw_r <= cw_nxt;
      prev_r  <= prev_nxt;   prev_v_r <= prev_v_nxt;  first_r <= first_nxt;
      col_r   <= col_nxt;    row_r <= row_nxt;    pass_r <= pass_nxt;
      pix_r   <= pix_nxt;    doe_r <= doe_nxt;    op_r <= op_nxt;
      if (cmd.load_out) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;   used_r <= used_nxt;  code_r <= code_nxt;
    byte_r <= byte_nxt;  taken_r <= taken_nxt;  pv_r <= pv_nxt;
    trans_r <= trans_nxt;  last_r <= last_nxt;  pidx_r <= pidx_nxt;
    px_r   <= px_nxt;    py_r <= py_nxt;
    total_r <= width_r * height_r;
    if (cmd.load_out) begin
      odata_r <= {3'b0, trans_r, py_r, px_r, pidx_r, pv_r, taken_r, status_c};
      olast_r <= last_r;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= 4'd8;  width_r <= 16'd1;  height_r <= 16'd1;  inter_r <= 1'b0;
      ccount_r <= 9'd256;  ten_r <= 1'b0;  tidx_r <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_CODE:  min_r    <= cfg_data[3:0];
        REG_WIDTH:     width_r  <= cfg_data;
        REG_HEIGHT:    height_r <= cfg_data;
        REG_INTERLACE: inter_r  <= cfg_data[0];
        REG_COLORS:    ccount_r <= cfg_data[8:0];
        REG_TRANS_EN:  ten_r    <= cfg_data[0];
        REG_TRANS_IDX: tidx_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Code tables: read at the next walk address, written when a string ends.
  always_ff @(posedge clk) begin
    pre_rd_r <= prefix_mem[cur_nxt[CODE_BITS-1:0]];
    suf_rd_r <= suffix_mem[cur_nxt[CODE_BITS-1:0]];
    if (tab_we) begin
      prefix_mem[next_r[CODE_BITS-1:0]] <= prev_r[CODE_BITS-1:0];
      suffix_mem[next_r[CODE_BITS-1:0]] <= cur_r[7:0];
    end
  end

  // String stack: pushed during the walk, top read for pulls.
  always_ff @(posedge clk) begin
    stk_rd_r <= stack_mem[stk_raddr];
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= TABLE_CODES) else $error("string stack depth beyond table size");
  a_bits_fit: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= 5'd20) else $error("bit buffer holds more bits than it can");
  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cw_r >= 4'd3) && (cw_r <= MAX_CODE_WIDTH)) else $error("code width out of range");
  a_next_max: assert property (@(posedge clk) disable iff (!rst_n)
    next_r <= TABLE_CODES) else $error("next code beyond table size");
`endif

endmodule
